// File: sv/cpu8_pkg.sv
`timescale 1ns / 1ps
package cpu8_pkg;

  typedef enum logic [5:0] {
    OP_ADC, OP_AND, OP_ASL, OP_BCC, OP_BCS, OP_BEQ, OP_BIT, OP_BMI, OP_BNE, OP_BPL,
    OP_BRK, OP_BVC, OP_BVS, OP_CLC, OP_CLD, OP_CLI, OP_CLV, OP_CMP, OP_CPX, OP_CPY,
    OP_DEC, OP_DEX, OP_DEY, OP_EOR, OP_INC, OP_INX, OP_INY, OP_JMP, OP_JSR, OP_LDA,
    OP_LDX, OP_LDY, OP_LSR, OP_NOP, OP_ORA, OP_PHA, OP_PHP, OP_PLA, OP_PLP, OP_ROL,
    OP_ROR, OP_RTI, OP_RTS, OP_SBC, OP_SEC, OP_SED, OP_SEI, OP_STA, OP_STX, OP_STY,
    OP_TAX, OP_TAY, OP_TSX, OP_TXA, OP_TXS, OP_TYA
  } op_t;

  typedef enum logic [3:0] {
    AM_IMP, AM_ACC, AM_IMM, AM_ZP, AM_ZPX, AM_ZPY, AM_REL, AM_ABS, AM_ABX, AM_ABY,
    AM_IND, AM_IXI, AM_IIX
  } am_t;

  typedef enum logic [1:0] {
    MODE_WRITE, MODE_READ, MODE_RESET, MODE_EXEC
  } mode_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RDB, S_RVLO, S_RVHI, S_B1, S_B2, S_ADR, S_PLO, S_PHI, S_EA, S_VAL,
    S_RUN, S_PULL1, S_PULL2, S_PULL3, S_PUSH2, S_PUSH3, S_BVLO, S_BVHI, S_FETCH,
    S_NXT, S_DONE
  } state_t;

  localparam logic CFG_IDX_ENABLE  = 1'b0;
  localparam logic CFG_IDX_ADDRESS = 1'b1;

  localparam logic [7:0]  STACK_PAGE = 8'h01;
  localparam logic [15:0] VEC_RESET  = 16'hFFFC;
  localparam logic [15:0] VEC_IRQ    = 16'hFFFE;
  localparam logic [7:0]  SP_RESET   = 8'hFD;
  localparam logic [7:0]  P_RESET    = 8'h24;
  localparam logic [7:0]  P_PUSH_SET = 8'h30;
  localparam logic [7:0]  P_PULL_CLR = 8'hEF;
  localparam logic [7:0]  P_PULL_SET = 8'h20;

  localparam int FC = 0;
  localparam int FZ = 1;
  localparam int FI = 2;
  localparam int FD = 3;
  localparam int FV = 6;
  localparam int FN = 7;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] sp;
    logic [7:0] p;
    logic       we;
    logic [7:0] wd;
    logic       taken;
  } alu_res_t;

  function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
    logic [7:0] q;
    q     = p;
    q[FZ] = (v == 8'h00);
    q[FN] = v[7];
    return q;
  endfunction

endpackage

// File: sv/eight_bit_cpu_instruction_executor.sv
`timescale 1ns / 1ps
// Sequence: memory writes, reads, core resets (override or vector) and instructions each
// run their own states; indirect modes add pointer reads, pulls add stack reads and BRK
// adds pushes and a vector fetch, and the result then goes to the output register.
// Flow: one beat at a time; every memory access goes through the single RAM, which has
// one write port and one read port.
// Reset: rst_n (synchronous, active low) clears the sequencer, the register file
// (sp 0xFD, status 0x24) and the config registers; memory content is undefined until written.
module eight_bit_cpu_instruction_executor
  import cpu8_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [15:0] in_mem_address,
  input  logic [7:0]  in_mem_data,
  input  logic [5:0]  in_instr_op,
  input  logic [3:0]  in_addr_mode,
  input  logic [1:0]  in_instr_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_prog_counter,
  output logic [7:0]  out_accum,
  output logic [7:0]  out_index_x,
  output logic [7:0]  out_index_y,
  output logic [7:0]  out_stack_pointer,
  output logic [7:0]  out_flags,
  output logic [7:0]  out_next_opcode_byte,
  output logic [7:0]  out_read_byte
);
  state_t state_r, state_nxt;

  // config
  logic        ovr_en_r;
  logic [15:0] ovr_addr_r;

  // architectural registers
  logic [15:0] pc_r, pc_nxt;
  logic [7:0]  a_r, a_nxt, x_r, x_nxt, y_r, y_nxt, sp_r, sp_nxt, p_r, p_nxt;

  // latched beat and work registers
  op_t         op_r, op_nxt;
  am_t         am_r, am_nxt;
  logic [1:0]  len_r, len_nxt;
  logic [7:0]  b1_r, b1_nxt, b2_r, b2_nxt, lo_r, lo_nxt, val_r, val_nxt;
  logic [7:0]  rb_r, rb_nxt, nob_r, nob_nxt;
  logic [15:0] ea_r, ea_nxt, ptr_r, ptr_nxt;
  logic        memop_r, memop_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] o_pc_r;
  logic [7:0]  o_a_r, o_x_r, o_y_r, o_sp_r, o_p_r, o_nob_r, o_rb_r;
  logic        out_load;

  // memory port
  logic        ram_we;
  logic [15:0] ram_waddr, ram_raddr;
  logic [7:0]  ram_wdata, ram_rdata;

  alu_res_t    alu;
  logic        in_fire;
  logic [15:0] absa, pc_len, pc_ret;
  logic [7:0]  ix_ptr, sp_inc;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid & in_ready;
  assign out_load = (state_r == S_DONE) & (~out_valid_r | out_ready);

  assign absa   = {b2_r, b1_r};
  assign pc_len = pc_r + {14'd0, len_r};
  assign pc_ret = pc_r + 16'd2;
  assign ix_ptr = b1_r + x_r;
  assign sp_inc = sp_r + 8'd1;

  cpu8_ram #(.W(8), .D(65536)) u_mem (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // one shared unit for the register and flag arithmetic of the instructions; stack ops adjust sp and flags outside it
  cpu8_alu u_alu (
    .op    (op_r),
    .am    (am_r),
    .memop (memop_r),
    .a     (a_r),
    .x     (x_r),
    .y     (y_r),
    .sp    (sp_r),
    .p     (p_r),
    .val   (val_r),
    .res   (alu)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (mode_t'(in_mode))
            MODE_WRITE: state_nxt = S_FETCH;
            MODE_READ:  state_nxt = S_RDB;
            MODE_RESET: state_nxt = ovr_en_r ? S_FETCH : S_RVLO;
            default:    state_nxt = S_B1;
          endcase
        end
      end
      S_RDB:  state_nxt = S_FETCH;
      S_RVLO: state_nxt = S_RVHI;
      S_RVHI: state_nxt = S_FETCH;
      S_B1:   state_nxt = S_B2;
      S_B2:   state_nxt = S_ADR;
      S_ADR: begin
        if (am_r == AM_IND || am_r == AM_IXI || am_r == AM_IIX) begin
          state_nxt = S_PLO;
        end else begin
          state_nxt = S_EA;
        end
      end
      S_PLO:  state_nxt = S_PHI;
      S_PHI:  state_nxt = S_EA;
      S_EA:   state_nxt = S_VAL;
      S_VAL:  state_nxt = S_RUN;
      S_RUN: begin
        case (op_r)
          OP_PLA, OP_PLP, OP_RTS, OP_RTI: state_nxt = S_PULL1;
          OP_JSR, OP_BRK:                 state_nxt = S_PUSH2;
          default:                        state_nxt = S_FETCH;
        endcase
      end
      S_PULL1: state_nxt = (op_r == OP_RTS || op_r == OP_RTI) ? S_PULL2 : S_FETCH;
      S_PULL2: state_nxt = (op_r == OP_RTI) ? S_PULL3 : S_FETCH;
      S_PULL3: state_nxt = S_FETCH;
      S_PUSH2: state_nxt = (op_r == OP_BRK) ? S_PUSH3 : S_FETCH;
      S_PUSH3: state_nxt = S_BVLO;
      S_BVLO:  state_nxt = S_BVHI;
      S_BVHI:  state_nxt = S_FETCH;
      S_FETCH: state_nxt = S_NXT;
      S_NXT:   state_nxt = S_DONE;
      S_DONE:  state_nxt = out_load ? S_IDLE : S_DONE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory port per state
  always_comb begin
    pc_nxt    = pc_r;
    a_nxt     = a_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    sp_nxt    = sp_r;
    p_nxt     = p_r;
    op_nxt    = op_r;
    am_nxt    = am_r;
    len_nxt   = len_r;
    b1_nxt    = b1_r;
    b2_nxt    = b2_r;
    lo_nxt    = lo_r;
    val_nxt   = val_r;
    rb_nxt    = rb_r;
    nob_nxt   = nob_r;
    ea_nxt    = ea_r;
    ptr_nxt   = ptr_r;
    memop_nxt = memop_r;
    ram_we    = 1'b0;
    ram_waddr = {STACK_PAGE, sp_r};
    ram_wdata = 8'h00;
    ram_raddr = pc_r;
    out_valid_nxt = out_load | (out_valid_r & ~out_ready);

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          // latch the beat
          op_nxt  = op_t'(in_instr_op);
          am_nxt  = am_t'(in_addr_mode);
          len_nxt = in_instr_length;
          rb_nxt  = 8'h00;
          case (mode_t'(in_mode))
            MODE_WRITE: begin
              ram_we    = 1'b1;
              ram_waddr = in_mem_address;
              ram_wdata = in_mem_data;
            end
            MODE_READ: ram_raddr = in_mem_address;
            MODE_RESET: begin
              a_nxt     = 8'h00;
              x_nxt     = 8'h00;
              y_nxt     = 8'h00;
              sp_nxt    = SP_RESET;
              p_nxt     = P_RESET;
              pc_nxt    = ovr_addr_r;
              ram_raddr = VEC_RESET;
            end
            default: ram_raddr = pc_r + 16'd1;
          endcase
        end
      end
      S_RDB:  rb_nxt = ram_rdata;
      S_RVLO: begin
        lo_nxt    = ram_rdata;
        ram_raddr = VEC_RESET + 16'd1;
      end
      S_RVHI: pc_nxt = {ram_rdata, lo_r};
      S_B1: begin
        b1_nxt    = (len_r[1]) ? ram_rdata : 8'h00;
        ram_raddr = pc_r + 16'd2;
      end
      S_B2: b2_nxt = (len_r == 2'd3) ? ram_rdata : 8'h00;
      S_ADR: begin
        // effective address; zero-page modes wrap within page zero
        memop_nxt = 1'b1;
        ea_nxt    = 16'h0000;
        case (am_r)
          AM_ZP:  ea_nxt = {8'h00, b1_r};
          AM_ZPX: ea_nxt = {8'h00, b1_r + x_r};
          AM_ZPY: ea_nxt = {8'h00, b1_r + y_r};
          AM_REL: begin
            ea_nxt    = pc_len + {{8{b1_r[7]}}, b1_r};
            memop_nxt = 1'b0;
          end
          AM_ABS: ea_nxt = absa;
          AM_ABX: ea_nxt = absa + {8'h00, x_r};
          AM_ABY: ea_nxt = absa + {8'h00, y_r};
          AM_IND: begin
            // pointer high byte stays in the same page
            ram_raddr = absa;
            ptr_nxt   = {absa[15:8], absa[7:0] + 8'd1};
          end
          AM_IXI: begin
            ram_raddr = {8'h00, ix_ptr};
            ptr_nxt   = {8'h00, ix_ptr + 8'd1};
          end
          AM_IIX: begin
            ram_raddr = {8'h00, b1_r};
            ptr_nxt   = {8'h00, b1_r + 8'd1};
          end
          default: memop_nxt = 1'b0;
        endcase
      end
      S_PLO: begin
        lo_nxt    = ram_rdata;
        ram_raddr = ptr_r;
      end
      S_PHI: ea_nxt = {ram_rdata, lo_r} + ((am_r == AM_IIX) ? {8'h00, y_r} : 16'h0000);
      S_EA:  ram_raddr = ea_r;
      S_VAL: begin
        if (am_r == AM_ACC) begin
          val_nxt = a_r;
        end else if (am_r == AM_IMM) begin
          val_nxt = b1_r;
        end else if (memop_r) begin
          val_nxt = ram_rdata;
        end else begin
          val_nxt = 8'h00;
        end
      end
      S_RUN: begin
        a_nxt  = alu.a;
        x_nxt  = alu.x;
        y_nxt  = alu.y;
        sp_nxt = alu.sp;
        p_nxt  = alu.p;
        if (alu.we) begin
          ram_we    = 1'b1;
          ram_waddr = ea_r;
          ram_wdata = alu.wd;
        end
        pc_nxt = (alu.taken || op_r == OP_JMP) ? ea_r : pc_len;
        case (op_r)
          OP_PHA, OP_PHP: begin
            ram_we    = 1'b1;
            ram_wdata = (op_r == OP_PHA) ? a_r : (p_r | P_PUSH_SET);
            sp_nxt    = sp_r - 8'd1;
          end
          OP_PLA, OP_PLP, OP_RTS, OP_RTI: begin
            sp_nxt    = sp_inc;
            ram_raddr = {STACK_PAGE, sp_inc};
            pc_nxt    = (op_r == OP_RTS || op_r == OP_RTI) ? pc_r : pc_len;
          end
          OP_JSR, OP_BRK: begin
            ram_we    = 1'b1;
            ram_wdata = pc_ret[15:8];
            sp_nxt    = sp_r - 8'd1;
            pc_nxt    = pc_r;
          end
          default: ;
        endcase
      end
      S_PULL1: begin
        case (op_r)
          OP_PLA: begin
            a_nxt = ram_rdata;
            p_nxt = set_nz(p_r, ram_rdata);
          end
          OP_RTS: begin
            lo_nxt    = ram_rdata;
            sp_nxt    = sp_inc;
            ram_raddr = {STACK_PAGE, sp_inc};
          end
          OP_RTI: begin
            p_nxt     = (ram_rdata & P_PULL_CLR) | P_PULL_SET;
            sp_nxt    = sp_inc;
            ram_raddr = {STACK_PAGE, sp_inc};
          end
          default: p_nxt = (ram_rdata & P_PULL_CLR) | P_PULL_SET;
        endcase
      end
      S_PULL2: begin
        if (op_r == OP_RTI) begin
          lo_nxt    = ram_rdata;
          sp_nxt    = sp_inc;
          ram_raddr = {STACK_PAGE, sp_inc};
        end else begin
          pc_nxt = {ram_rdata, lo_r} + 16'd1;
        end
      end
      S_PULL3: pc_nxt = {ram_rdata, lo_r};
      S_PUSH2: begin
        ram_we    = 1'b1;
        ram_wdata = pc_ret[7:0];
        sp_nxt    = sp_r - 8'd1;
        if (op_r == OP_JSR) begin
          pc_nxt = ea_r;
        end
      end
      S_PUSH3: begin
        ram_we    = 1'b1;
        ram_wdata = p_r | P_PUSH_SET;
        sp_nxt    = sp_r - 8'd1;
        p_nxt[FI] = 1'b1;
        ram_raddr = VEC_IRQ;
      end
      S_BVLO: begin
        lo_nxt    = ram_rdata;
        ram_raddr = VEC_IRQ + 16'd1;
      end
      S_BVHI:  pc_nxt = {ram_rdata, lo_r};
      S_FETCH: ram_raddr = pc_r;
      S_NXT:   nob_nxt = ram_rdata;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      ovr_en_r    <= 1'b0;
      ovr_addr_r  <= 16'h0000;
      pc_r        <= 16'h0000;
      a_r         <= 8'h00;
      x_r         <= 8'h00;
      y_r         <= 8'h00;
      sp_r        <= SP_RESET;
      p_r         <= P_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pc_r        <= pc_nxt;
      a_r         <= a_nxt;
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      sp_r        <= sp_nxt;
      p_r         <= p_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_IDX_ENABLE) begin
          ovr_en_r <= cfg_data[0];
        end else begin
          ovr_addr_r <= cfg_data;
        end
      end
    end
  end

  // work registers and result payload: no reset needed
  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    am_r    <= am_nxt;
    len_r   <= len_nxt;
    b1_r    <= b1_nxt;
    b2_r    <= b2_nxt;
    lo_r    <= lo_nxt;
    val_r   <= val_nxt;
    rb_r    <= rb_nxt;
    nob_r   <= nob_nxt;
    ea_r    <= ea_nxt;
    ptr_r   <= ptr_nxt;
    memop_r <= memop_nxt;
    if (out_load) begin
      o_pc_r  <= pc_r;
      o_a_r   <= a_r;
      o_x_r   <= x_r;
      o_y_r   <= y_r;
      o_sp_r  <= sp_r;
      o_p_r   <= p_r;
      o_nob_r <= nob_r;
      o_rb_r  <= rb_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_prog_counter     = o_pc_r;
  assign out_accum            = o_a_r;
  assign out_index_x          = o_x_r;
  assign out_index_y          = o_y_r;
  assign out_stack_pointer    = o_sp_r;
  assign out_flags            = o_p_r;
  assign out_next_opcode_byte = o_nob_r;
  assign out_read_byte        = o_rb_r;

  a_exec_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_mode == MODE_EXEC |=> state_r == S_B1)
    else $error("execute beat did not start operand fetch");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r && state_r == S_IDLE)
    else $error("finished beat not presented");

  a_brk_sets_i: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PUSH3 |=> p_r[FI] && sp_r == $past(sp_r) - 8'd1)
    else $error("BRK status push did not set I and drop sp");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE && !in_fire |-> !ram_we)
    else $error("memory written while idle");
endmodule

// File: sv/cpu8_ram.sv
`timescale 1ns / 1ps
module cpu8_ram #(
  parameter int W = 8,
  parameter int D = 65536
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: sv/cpu8_alu.sv
`timescale 1ns / 1ps
module cpu8_alu
  import cpu8_pkg::*;
(
  input  op_t        op,
  input  am_t        am,
  input  logic       memop,
  input  logic [7:0] a,
  input  logic [7:0] x,
  input  logic [7:0] y,
  input  logic [7:0] sp,
  input  logic [7:0] p,
  input  logic [7:0] val,
  output alu_res_t   res
);
  logic [8:0] sum;
  logic [7:0] addend;
  logic [7:0] cmp_reg;
  logic [8:0] diff;
  logic [7:0] r;
  logic       rc;

  always_comb begin
    addend  = (op == OP_SBC) ? ~val : val;
    sum     = {1'b0, a} + {1'b0, addend} + {8'h00, p[FC]};
    cmp_reg = (op == OP_CPX) ? x : ((op == OP_CPY) ? y : a);
    diff    = {1'b0, cmp_reg} - {1'b0, val};
    r       = val;
    rc      = p[FC];
    case (op)
      OP_INC:  r = val + 8'd1;
      OP_DEC:  r = val - 8'd1;
      OP_ASL: begin r = {val[6:0], 1'b0};  rc = val[7]; end
      OP_LSR: begin r = {1'b0, val[7:1]};  rc = val[0]; end
      OP_ROL: begin r = {val[6:0], p[FC]}; rc = val[7]; end
      OP_ROR: begin r = {p[FC], val[7:1]}; rc = val[0]; end
      default: ;
    endcase

    res       = '0;
    res.a     = a;
    res.x     = x;
    res.y     = y;
    res.sp    = sp;
    res.p     = p;
    case (op)
      OP_LDA: begin res.a = val; res.p = set_nz(p, val); end
      OP_LDX: begin res.x = val; res.p = set_nz(p, val); end
      OP_LDY: begin res.y = val; res.p = set_nz(p, val); end
      OP_STA: begin res.we = memop; res.wd = a; end
      OP_STX: begin res.we = memop; res.wd = x; end
      OP_STY: begin res.we = memop; res.wd = y; end
      OP_TAX: begin res.x = a;  res.p = set_nz(p, a); end
      OP_TAY: begin res.y = a;  res.p = set_nz(p, a); end
      OP_TXA: begin res.a = x;  res.p = set_nz(p, x); end
      OP_TYA: begin res.a = y;  res.p = set_nz(p, y); end
      OP_TSX: begin res.x = sp; res.p = set_nz(p, sp); end
      OP_TXS: res.sp = x;
      OP_AND: begin res.a = a & val; res.p = set_nz(p, a & val); end
      OP_EOR: begin res.a = a ^ val; res.p = set_nz(p, a ^ val); end
      OP_ORA: begin res.a = a | val; res.p = set_nz(p, a | val); end
      OP_BIT: begin
        res.p[FZ] = ((a & val) == 8'h00);
        res.p[FN] = val[7];
        res.p[FV] = val[6];
      end
      OP_ADC, OP_SBC: begin
        res.a     = sum[7:0];
        res.p     = set_nz(p, sum[7:0]);
        res.p[FC] = sum[8];
        res.p[FV] = ~(a[7] ^ addend[7]) & (a[7] ^ sum[7]);
      end
      OP_CMP, OP_CPX, OP_CPY: begin
        res.p[FC] = ~diff[8];
        res.p[FZ] = (cmp_reg == val);
        res.p[FN] = diff[7];
      end
      OP_INX: begin res.x = x + 8'd1; res.p = set_nz(p, x + 8'd1); end
      OP_INY: begin res.y = y + 8'd1; res.p = set_nz(p, y + 8'd1); end
      OP_DEX: begin res.x = x - 8'd1; res.p = set_nz(p, x - 8'd1); end
      OP_DEY: begin res.y = y - 8'd1; res.p = set_nz(p, y - 8'd1); end
      OP_INC, OP_DEC, OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
        res.p     = set_nz(p, r);
        res.p[FC] = rc;
        if (am == AM_ACC) begin
          res.a = r;
        end else begin
          res.we = memop;
          res.wd = r;
        end
      end
      OP_BCC: res.taken = ~p[FC];
      OP_BCS: res.taken = p[FC];
      OP_BEQ: res.taken = p[FZ];
      OP_BNE: res.taken = ~p[FZ];
      OP_BMI: res.taken = p[FN];
      OP_BPL: res.taken = ~p[FN];
      OP_BVC: res.taken = ~p[FV];
      OP_BVS: res.taken = p[FV];
      OP_CLC: res.p[FC] = 1'b0;
      OP_CLD: res.p[FD] = 1'b0;
      OP_CLI: res.p[FI] = 1'b0;
      OP_CLV: res.p[FV] = 1'b0;
      OP_SEC: res.p[FC] = 1'b1;
      OP_SED: res.p[FD] = 1'b1;
      OP_SEI: res.p[FI] = 1'b1;
      default: ;
    endcase
  end
endmodule

// File: tb/eight_bit_cpu_instruction_executor_tb.sv
`timescale 1ns / 1ps
module eight_bit_cpu_instruction_executor_tb
  import cpu8_pkg::*;
();

  // One result beat: the register file after an item, plus the two memory views.
  typedef struct packed {
    logic [15:0] pc;
    logic [7:0]  a;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  sp;
    logic [7:0]  p;
    logic [7:0]  nob;
    logic [7:0]  rb;
  } core_view_t;

  // One input beat.
  typedef struct {
    mode_t       mode;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [5:0]  op;
    logic [3:0]  am;
    logic [1:0]  len;
  } cmd_t;

  typedef struct {
    cmd_t       c;
    bit         typed;
    core_view_t want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = 16'h0000;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_mode = 2'd0;
  logic [15:0] in_mem_address = 16'h0000;
  logic [7:0]  in_mem_data = 8'h00;
  logic [5:0]  in_instr_op = 6'd0;
  logic [3:0]  in_addr_mode = 4'd0;
  logic [1:0]  in_instr_length = 2'd1;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_prog_counter;
  logic [7:0]  out_accum;
  logic [7:0]  out_index_x;
  logic [7:0]  out_index_y;
  logic [7:0]  out_stack_pointer;
  logic [7:0]  out_flags;
  logic [7:0]  out_next_opcode_byte;
  logic [7:0]  out_read_byte;

  eight_bit_cpu_instruction_executor uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_mode              (in_mode),
    .in_mem_address       (in_mem_address),
    .in_mem_data          (in_mem_data),
    .in_instr_op          (in_instr_op),
    .in_addr_mode         (in_addr_mode),
    .in_instr_length      (in_instr_length),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_prog_counter     (out_prog_counter),
    .out_accum            (out_accum),
    .out_index_x          (out_index_x),
    .out_index_y          (out_index_y),
    .out_stack_pointer    (out_stack_pointer),
    .out_flags            (out_flags),
    .out_next_opcode_byte (out_next_opcode_byte),
    .out_read_byte        (out_read_byte)
  );

  always #5 clk = ~clk;

  // Shadow core: registers, config and memory, plus a record of which bytes hold data.
  logic [15:0] core_pc;
  logic [7:0]  core_a, core_x, core_y, core_sp, core_p;
  logic        start_en;
  logic [15:0] start_addr;
  logic [7:0]  shadow_mem [0:65535];
  bit          loaded [0:65535];

  // In a dry run, stores are dropped and reads of unloaded bytes are collected here.
  bit          dry_run;
  logic [15:0] unloaded_q [$];

  core_view_t  pending_q [$];

  int          mismatches;
  int          beats_seen;
  int          n_exec, n_reset, n_loads;
  int          burst_left;
  bit          tx_gaps;
  bit          rx_free = 1'b1;
  logic [15:0] rx_shape = 16'hFFFF;
  logic [3:0]  rx_phase = 4'd0;

  function automatic logic [7:0] peek(input logic [15:0] a);
    if (!loaded[a]) begin
      if (dry_run) unloaded_q.push_back(a);
      return 8'h00;
    end
    return shadow_mem[a];
  endfunction

  function automatic void poke(input logic [15:0] a, input logic [7:0] v);
    if (!dry_run) begin
      shadow_mem[a] = v;
      loaded[a]     = 1'b1;
    end
  endfunction

  function automatic void push_byte(input logic [7:0] v);
    poke({STACK_PAGE, core_sp}, v);
    core_sp = core_sp - 8'd1;
  endfunction

  function automatic logic [7:0] pull_byte();
    core_sp = core_sp + 8'd1;
    return peek({STACK_PAGE, core_sp});
  endfunction

  function automatic void mark_nz(input logic [7:0] v);
    core_p[FZ] = (v == 8'h00);
    core_p[FN] = v[7];
  endfunction

  function automatic void add_into_a(input logic [7:0] v);
    logic [8:0] s;
    s = {1'b0, core_a} + {1'b0, v} + {8'h00, core_p[FC]};
    core_p[FC] = s[8];
    core_p[FV] = (core_a[7] == v[7]) && (s[7] != core_a[7]);
    core_a = s[7:0];
    mark_nz(core_a);
  endfunction

  function automatic void compare_reg(input logic [7:0] r, input logic [7:0] v);
    logic [7:0] d;
    d = r - v;
    core_p[FC] = (r >= v);
    core_p[FZ] = (r == v);
    core_p[FN] = d[7];
  endfunction

  function automatic void run_instr(input logic [5:0] op, input logic [3:0] am,
                                    input logic [1:0] len);
    logic [7:0]  b1, b2, val, r, zp, lo, hi;
    logic [15:0] absa, ea, ptr, nxt;
    bit          memop, branch, taken;
    b1     = (len >= 2) ? peek(core_pc + 16'd1) : 8'h00;
    b2     = (len >= 3) ? peek(core_pc + 16'd2) : 8'h00;
    absa   = {b2, b1};
    ea     = 16'h0000;
    memop  = 1'b1;
    branch = 1'b0;
    taken  = 1'b0;
    val    = 8'h00;
    nxt    = core_pc + {14'd0, len};
    case (am)
      AM_ZP:  ea = {8'h00, b1};
      AM_ZPX: begin
        zp = b1 + core_x;
        ea = {8'h00, zp};
      end
      AM_ZPY: begin
        zp = b1 + core_y;
        ea = {8'h00, zp};
      end
      AM_REL: begin
        ea    = core_pc + {14'd0, len} + {{8{b1[7]}}, b1};
        memop = 1'b0;
      end
      AM_ABS: ea = absa;
      AM_ABX: ea = absa + {8'h00, core_x};
      AM_ABY: ea = absa + {8'h00, core_y};
      AM_IND: begin
        // high byte of the pointer stays in the same page
        lo = peek(absa);
        hi = peek({absa[15:8], absa[7:0] + 8'd1});
        ea = {hi, lo};
      end
      AM_IXI: begin
        zp = b1 + core_x;
        lo = peek({8'h00, zp});
        hi = peek({8'h00, zp + 8'd1});
        ea = {hi, lo};
      end
      AM_IIX: begin
        lo  = peek({8'h00, b1});
        hi  = peek({8'h00, b1 + 8'd1});
        ptr = {hi, lo};
        ea  = ptr + {8'h00, core_y};
      end
      default: memop = 1'b0;
    endcase
    if (am == AM_ACC) val = core_a;
    else if (am == AM_IMM) val = b1;
    else if (memop) val = peek(ea);

    case (op)
      OP_LDA: begin core_a = val; mark_nz(val); end
      OP_LDX: begin core_x = val; mark_nz(val); end
      OP_LDY: begin core_y = val; mark_nz(val); end
      OP_STA: if (memop) poke(ea, core_a);
      OP_STX: if (memop) poke(ea, core_x);
      OP_STY: if (memop) poke(ea, core_y);
      OP_TAX: begin core_x = core_a; mark_nz(core_x); end
      OP_TAY: begin core_y = core_a; mark_nz(core_y); end
      OP_TXA: begin core_a = core_x; mark_nz(core_a); end
      OP_TYA: begin core_a = core_y; mark_nz(core_a); end
      OP_TSX: begin core_x = core_sp; mark_nz(core_x); end
      OP_TXS: core_sp = core_x;
      OP_PHA: push_byte(core_a);
      OP_PHP: push_byte(core_p | P_PUSH_SET);
      OP_PLA: begin core_a = pull_byte(); mark_nz(core_a); end
      OP_PLP: core_p = (pull_byte() & P_PULL_CLR) | P_PULL_SET;
      OP_AND: begin core_a = core_a & val; mark_nz(core_a); end
      OP_EOR: begin core_a = core_a ^ val; mark_nz(core_a); end
      OP_ORA: begin core_a = core_a | val; mark_nz(core_a); end
      OP_BIT: begin
        core_p[FZ] = ((core_a & val) == 8'h00);
        core_p[FN] = val[7];
        core_p[FV] = val[6];
      end
      OP_ADC: add_into_a(val);
      OP_SBC: add_into_a(~val);
      OP_CMP: compare_reg(core_a, val);
      OP_CPX: compare_reg(core_x, val);
      OP_CPY: compare_reg(core_y, val);
      OP_INX: begin core_x = core_x + 8'd1; mark_nz(core_x); end
      OP_INY: begin core_y = core_y + 8'd1; mark_nz(core_y); end
      OP_DEX: begin core_x = core_x - 8'd1; mark_nz(core_x); end
      OP_DEY: begin core_y = core_y - 8'd1; mark_nz(core_y); end
      OP_INC, OP_DEC, OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
        case (op)
          OP_INC: r = val + 8'd1;
          OP_DEC: r = val - 8'd1;
          OP_ASL: begin r = {val[6:0], 1'b0};       core_p[FC] = val[7]; end
          OP_LSR: begin r = {1'b0, val[7:1]};       core_p[FC] = val[0]; end
          OP_ROL: begin r = {val[6:0], core_p[FC]}; core_p[FC] = val[7]; end
          default: begin r = {core_p[FC], val[7:1]}; core_p[FC] = val[0]; end
        endcase
        // imp, imm and rel drop the result but keep the flags
        if (am == AM_ACC) core_a = r;
        else if (memop) poke(ea, r);
        mark_nz(r);
      end
      OP_JMP: nxt = ea;
      OP_JSR: begin
        ptr = core_pc + 16'd2;
        push_byte(ptr[15:8]);
        push_byte(ptr[7:0]);
        nxt = ea;
      end
      OP_RTS: begin
        lo  = pull_byte();
        hi  = pull_byte();
        nxt = {hi, lo} + 16'd1;
      end
      OP_RTI: begin
        core_p = (pull_byte() & P_PULL_CLR) | P_PULL_SET;
        lo     = pull_byte();
        hi     = pull_byte();
        nxt    = {hi, lo};
      end
      OP_BRK: begin
        ptr = core_pc + 16'd2;
        push_byte(ptr[15:8]);
        push_byte(ptr[7:0]);
        push_byte(core_p | P_PUSH_SET);
        core_p[FI] = 1'b1;
        lo  = peek(VEC_IRQ);
        hi  = peek(VEC_IRQ + 16'd1);
        nxt = {hi, lo};
      end
      OP_BCC: begin branch = 1'b1; taken = !core_p[FC]; end
      OP_BCS: begin branch = 1'b1; taken = core_p[FC]; end
      OP_BEQ: begin branch = 1'b1; taken = core_p[FZ]; end
      OP_BNE: begin branch = 1'b1; taken = !core_p[FZ]; end
      OP_BMI: begin branch = 1'b1; taken = core_p[FN]; end
      OP_BPL: begin branch = 1'b1; taken = !core_p[FN]; end
      OP_BVC: begin branch = 1'b1; taken = !core_p[FV]; end
      OP_BVS: begin branch = 1'b1; taken = core_p[FV]; end
      OP_CLC: core_p[FC] = 1'b0;
      OP_CLD: core_p[FD] = 1'b0;
      OP_CLI: core_p[FI] = 1'b0;
      OP_CLV: core_p[FV] = 1'b0;
      OP_SEC: core_p[FC] = 1'b1;
      OP_SED: core_p[FD] = 1'b1;
      OP_SEI: core_p[FI] = 1'b1;
      default: ;
    endcase
    if (branch && taken) nxt = ea;
    core_pc = nxt;
  endfunction

  // Advance the shadow core by one beat and return the view it should show.
  function automatic core_view_t step_core(input cmd_t c);
    core_view_t v;
    logic [7:0] rb, lo, hi;
    rb = 8'h00;
    case (c.mode)
      MODE_WRITE: poke(c.addr, c.data);
      MODE_READ:  rb = peek(c.addr);
      MODE_RESET: begin
        core_a  = 8'h00;
        core_x  = 8'h00;
        core_y  = 8'h00;
        core_sp = SP_RESET;
        core_p  = P_RESET;
        if (start_en) begin
          core_pc = start_addr;
        end else begin
          lo      = peek(VEC_RESET);
          hi      = peek(VEC_RESET + 16'd1);
          core_pc = {hi, lo};
        end
      end
      default: begin
        n_exec++;
        run_instr(c.op, c.am, c.len);
      end
    endcase
    if (c.mode == MODE_RESET) n_reset++;
    v.pc  = core_pc;
    v.a   = core_a;
    v.x   = core_x;
    v.y   = core_y;
    v.sp  = core_sp;
    v.p   = core_p;
    v.nob = peek(core_pc);
    v.rb  = rb;
    return v;
  endfunction

  // Dry run: find every unloaded byte the beat would read, leave the core untouched.
  function automatic void find_unloaded(input cmd_t c);
    logic [15:0] spc;
    logic [7:0]  sa, sx, sy, ss, sp;
    int          se, sr;
    core_view_t  dummy;
    spc = core_pc; sa = core_a; sx = core_x; sy = core_y; ss = core_sp; sp = core_p;
    se = n_exec; sr = n_reset;
    unloaded_q.delete();
    dry_run = 1'b1;
    dummy   = step_core(c);
    dry_run = 1'b0;
    core_pc = spc; core_a = sa; core_x = sx; core_y = sy; core_sp = ss; core_p = sp;
    n_exec = se; n_reset = sr;
  endfunction

  task automatic drive_beat(input cmd_t c);
    if (burst_left == 0) begin
      if (tx_gaps) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid        <= 1'b1;
    in_mode         <= c.mode;
    in_mem_address  <= c.addr;
    in_mem_data     <= c.data;
    in_instr_op     <= c.op;
    in_addr_mode    <= c.am;
    in_instr_length <= c.len;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_beat(input cmd_t c, input bit typed, input core_view_t want);
    core_view_t v;
    v = step_core(c);
    pending_q.push_back(typed ? want : v);
    drive_beat(c);
  endtask

  function automatic cmd_t mk(input mode_t m, input logic [15:0] a, input logic [7:0] d,
                              input logic [5:0] op, input logic [3:0] am,
                              input logic [1:0] len);
    cmd_t c;
    c.mode = m; c.addr = a; c.data = d; c.op = op; c.am = am; c.len = len;
    return c;
  endfunction

  // Load every unloaded byte the beat would read with random data first, then send it.
  task automatic issue(input cmd_t c, input bit typed = 1'b0,
                       input core_view_t want = '0);
    logic [15:0] a;
    forever begin
      find_unloaded(c);
      if (unloaded_q.size() == 0) break;
      while (unloaded_q.size() != 0) begin
        a = unloaded_q.pop_front();
        if (!loaded[a]) begin
          n_loads++;
          send_beat(mk(MODE_WRITE, a, 8'($urandom), OP_NOP, AM_IMP, 2'd1), 1'b0, '0);
        end
      end
    end
    send_beat(c, typed, want);
  endtask

  // Drop valid and hold until every outstanding beat has come back.
  task automatic drain();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_start(input logic en, input logic [15:0] addr);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IDX_ENABLE;
    cfg_data  <= {15'd0, en};
    @(posedge clk);
    cfg_index <= CFG_IDX_ADDRESS;
    cfg_data  <= addr;
    @(posedge clk);
    cfg_we     <= 1'b0;
    start_en   = en;
    start_addr = addr;
  endtask

  function automatic logic [1:0] usual_len(input logic [3:0] am);
    if (am == AM_IMP || am == AM_ACC) return 2'd1;
    if (am >= AM_ABS && am <= AM_IND) return 2'd3;
    return 2'd2;
  endfunction

  // Random beat, mostly instructions; steer operand bytes toward the wrap corners.
  task automatic random_beat();
    int          pick;
    logic [5:0]  op;
    logic [3:0]  am;
    logic [1:0]  len;
    logic [7:0]  corner [4];
    corner = '{8'h00, 8'h7F, 8'h80, 8'hFF};
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      issue(mk(MODE_WRITE, 16'($urandom), 8'($urandom), 6'($urandom), 4'($urandom), 2'd1));
    end else if (pick < 18) begin
      issue(mk(MODE_READ, ($urandom_range(0, 1) != 0) ? core_pc + 16'($urandom_range(0, 7))
                                                    : 16'($urandom),
               8'($urandom), OP_NOP, AM_IMP, 2'd1));
    end else if (pick < 21) begin
      issue(mk(MODE_RESET, 16'($urandom), 8'($urandom), OP_NOP, AM_IMP, 2'd1));
    end else begin
      op = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(56, 63))
                                        : 6'($urandom_range(0, 55));
      am = 4'($urandom_range(0, 12));
      if (op >= OP_BCC && op <= OP_BVS && op != OP_BIT && op != OP_BRK &&
          $urandom_range(0, 3) != 0)
        am = AM_REL;
      len = ($urandom_range(0, 4) == 0) ? 2'($urandom_range(1, 3)) : usual_len(am);
      if (len >= 2 && $urandom_range(0, 3) == 0)
        issue(mk(MODE_WRITE, core_pc + 16'd1, corner[$urandom_range(0, 3)],
                 OP_NOP, AM_IMP, 2'd1));
      if (len == 3 && $urandom_range(0, 5) == 0)
        issue(mk(MODE_WRITE, core_pc + 16'd2, corner[$urandom_range(0, 3)],
                 OP_NOP, AM_IMP, 2'd1));
      issue(mk(MODE_EXEC, 16'($urandom), 8'($urandom), op, am, len));
    end
  endtask

  // Receiver: stall on a rotating pattern or stay ready; check every beat taken.
  always @(posedge clk) begin
    core_view_t got, want;
    logic [15:0] g [8];
    logic [15:0] w [8];
    string       nm [8];
    bit          bad;
    rx_phase  <= rx_phase + 4'd1;
    out_ready <= rx_free | rx_shape[rx_phase];
    if (rst_n && out_valid && out_ready) begin
      beats_seen++;
      got = '{out_prog_counter, out_accum, out_index_x, out_index_y, out_stack_pointer,
              out_flags, out_next_opcode_byte, out_read_byte};
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat pc=%h", got.pc);
      end else begin
        want = pending_q.pop_front();
        nm = '{"prog_counter", "accum", "index_x", "index_y", "stack_pointer", "flags",
               "next_opcode_byte", "read_byte"};
        g = '{got.pc, got.a, got.x, got.y, got.sp, got.p, got.nob, got.rb};
        w = '{want.pc, want.a, want.x, want.y, want.sp, want.p, want.nob, want.rb};
        bad = 1'b0;
        for (int i = 0; i < 8; i++) begin
          if (g[i] !== w[i]) begin
            if (!bad) mismatches++;
            bad = 1'b1;
            if (mismatches <= 10)
              $display("beat %0d %s: expected %h got %h", beats_seen, nm[i], w[i], g[i]);
          end
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL eight_bit_cpu_instruction_executor");
    $finish;
  end

  initial begin
    row_t        rows [$];
    logic [15:0] starts_addr [5];
    logic        starts_en [5];
    core_pc = 16'h0000; core_a = 8'h00; core_x = 8'h00; core_y = 8'h00;
    core_sp = SP_RESET; core_p = P_RESET;
    start_en = 1'b0; start_addr = 16'h0000;
    dry_run = 1'b0;
    mismatches = 0; beats_seen = 0; n_exec = 0; n_reset = 0; n_loads = 0;
    burst_left = 0;
    tx_gaps = 1'b0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_start(1'b0, 16'h0000);

    // Directed beats. Only the first few have results that are obvious by hand.
    rows.push_back('{mk(MODE_WRITE, 16'h0000, 8'h00, OP_NOP, AM_IMP, 2'd1), 1'b1,
                     core_view_t'({16'h0000, 8'h00, 8'h00, 8'h00, 8'hFD, 8'h24, 8'h00, 8'h00})});
    rows.push_back('{mk(MODE_WRITE, 16'h0001, 8'h80, OP_NOP, AM_IMP, 2'd1), 1'b1,
                     core_view_t'({16'h0000, 8'h00, 8'h00, 8'h00, 8'hFD, 8'h24, 8'h00, 8'h00})});
    rows.push_back('{mk(MODE_WRITE, 16'hFFFF, 8'hFF, OP_NOP, AM_IMP, 2'd1), 1'b1,
                     core_view_t'({16'h0000, 8'h00, 8'h00, 8'h00, 8'hFD, 8'h24, 8'h00, 8'h00})});
    rows.push_back('{mk(MODE_READ, 16'hFFFF, 8'h00, OP_NOP, AM_IMP, 2'd1), 1'b1,
                     core_view_t'({16'h0000, 8'h00, 8'h00, 8'h00, 8'hFD, 8'h24, 8'h00, 8'hFF})});
    rows.push_back('{mk(MODE_EXEC, 16'h0000, 8'h00, OP_LDA, AM_IMM, 2'd2), 1'b0, '0});
    rows.push_back('{mk(MODE_EXEC, 16'h0000, 8'h00, OP_ADC, AM_IMM, 2'd2), 1'b0, '0});
    rows.push_back('{mk(MODE_EXEC, 16'h0000, 8'h00, OP_SEC, AM_IMP, 2'd1), 1'b0, '0});
    rows.push_back('{mk(MODE_EXEC, 16'h0000, 8'h00, OP_SBC, AM_ZP,  2'd2), 1'b0, '0});
    rows.push_back('{mk(MODE_EXEC, 16'h0000, 8'h00, OP_LDX, AM_ZPY, 2'd2), 1'b0, '0});
    rows.push_back('{mk(MODE_EXEC, 16'h0000, 8'h00, OP_ROR, AM_ZPX, 2'd2), 1'b0, '0});
    rows.push_back('{mk(MODE_EXEC, 16'h0000, 8'h00, OP_ASL, AM_ACC, 2'd1), 1'b0, '0});
    rows.push_back('{mk(MODE_EXEC, 16'h0000, 8'h00, OP_INC, AM_IMP, 2'd1), 1'b0, '0});
    rows.push_back('{mk(MODE_EXEC, 16'h0000, 8'h00, OP_PHA, AM_IMP, 2'd1), 1'b0, '0});
    rows.push_back('{mk(MODE_EXEC, 16'h0000, 8'h00, OP_PHP, AM_IMP, 2'd1), 1'b0, '0});
    rows.push_back('{mk(MODE_EXEC, 16'h0000, 8'h00, OP_PLP, AM_IMP, 2'd1), 1'b0, '0});
    rows.push_back('{mk(MODE_EXEC, 16'h0000, 8'h00, OP_PLA, AM_IMP, 2'd1), 1'b0, '0});
    rows.push_back('{mk(MODE_EXEC, 16'h0000, 8'h00, OP_STA, AM_IIX, 2'd2), 1'b0, '0});
    rows.push_back('{mk(MODE_EXEC, 16'h0000, 8'h00, OP_LDA, AM_IXI, 2'd2), 1'b0, '0});
    rows.push_back('{mk(MODE_EXEC, 16'h0000, 8'h00, OP_CMP, AM_ABY, 2'd3), 1'b0, '0});
    rows.push_back('{mk(MODE_EXEC, 16'h0000, 8'h00, OP_DEC, AM_ABX, 2'd3), 1'b0, '0});
    rows.push_back('{mk(MODE_EXEC, 16'h0000, 8'h00, OP_BNE, AM_REL, 2'd2), 1'b0, '0});
    rows.push_back('{mk(MODE_EXEC, 16'h0000, 8'h00, OP_JSR, AM_ABS, 2'd3), 1'b0, '0});
    rows.push_back('{mk(MODE_EXEC, 16'h0000, 8'h00, OP_RTS, AM_IMP, 2'd1), 1'b0, '0});
    rows.push_back('{mk(MODE_EXEC, 16'h0000, 8'h00, OP_BRK, AM_IMP, 2'd1), 1'b0, '0});
    rows.push_back('{mk(MODE_EXEC, 16'h0000, 8'h00, OP_RTI, AM_IMP, 2'd1), 1'b0, '0});
    rows.push_back('{mk(MODE_EXEC, 16'h0000, 8'h00, OP_JMP, AM_IND, 2'd3), 1'b0, '0});
    rows.push_back('{mk(MODE_EXEC, 16'h0000, 8'h00, 6'd63, AM_IMP, 2'd1), 1'b0, '0});
    foreach (rows[i]) issue(rows[i].c, rows[i].typed, rows[i].want);

    // Random phases, each under its own start setting and handshake shape.
    starts_en   = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0};
    starts_addr = '{16'h0000, 16'hFFFF, 16'h0000, 16'($urandom), 16'($urandom)};
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      set_start(starts_en[ph], starts_addr[ph]);
      rx_free  <= (ph == 0);
      rx_shape <= 16'($urandom) | 16'h0101;
      tx_gaps  = (ph != 2);
      issue(mk(MODE_RESET, 16'h0000, 8'h00, OP_NOP, AM_IMP, 2'd1));
      repeat (50) random_beat();
    end

    drain();
    repeat (40) @(posedge clk);
    $display("covered %0d result beats: %0d instructions, %0d core resets, %0d memory loads",
             beats_seen, n_exec, n_reset, n_loads);
    $display("five start settings (vector, override at 0000, FFFF and random addresses)");
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("PASS eight_bit_cpu_instruction_executor");
    end else begin
      $display("FAIL eight_bit_cpu_instruction_executor");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/cpu8_pkg.sv
sv/cpu8_ram.sv
sv/cpu8_alu.sv
sv/eight_bit_cpu_instruction_executor.sv
tb/eight_bit_cpu_instruction_executor_tb.sv
